// ===== design/rqfl_pkg.sv =====
`timescale 1ns / 1ps

package rqfl_pkg;

   // Position of the length byte within a reply frame
   localparam int unsigned LENGTH_INDEX = 2;

   localparam int unsigned RESULTS_MAX = 4;
   localparam int unsigned COUNT_W     = $clog2(RESULTS_MAX + 1);

   localparam logic [7:0]  HEADER_RESET  = 8'd0;
   localparam logic [7:0]  PREFIX_RESET  = 8'd0;
   localparam logic [7:0]  ERR1_RESET    = 8'd0;
   localparam logic [7:0]  ERR2_RESET    = 8'd0;
   localparam logic [8:0]  INIT_LEN_RESET = 9'd3;
   localparam logic [8:0]  MAX_LEN_RESET  = 9'd257;
   localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;

   typedef enum logic [2:0] {
      REG_HEADER   = 3'd0,
      REG_PREFIX   = 3'd1,
      REG_ERR1     = 3'd2,
      REG_ERR2     = 3'd3,
      REG_INIT_LEN = 3'd4,
      REG_MAX_LEN  = 3'd5,
      REG_TIMEOUT  = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_START = 2'd0,
      MODE_BYTE  = 2'd1,
      MODE_TICK  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_COMMAND = 2'd0,
      KIND_ECHO    = 2'd1,
      KIND_STATUS  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK            = 3'd0,
      STATUS_TIMEOUT_EMPTY = 3'd1,
      STATUS_TIMEOUT_PART  = 3'd2,
      STATUS_ERROR_REPLY   = 3'd3,
      STATUS_BAD_LENGTH    = 3'd4,
      STATUS_CHECKSUM      = 3'd5
   } status_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic [8:0] byte_index;
      status_type status;
      logic       last;
   } result_type;

   typedef struct packed {
      logic [COUNT_W-1:0]             count;
      result_type [RESULTS_MAX-1:0]   entry;
   } bundle_type;

endpackage

// ===== design/rqfl_result_stage.sv =====
`timescale 1ns / 1ps

module rqfl_result_stage import rqfl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  bundle_type  bundle,
   output logic        can_load,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // data_byte [7:0], byte_index [16:8], status [19:17]
   output logic [1:0]  rsp_tuser,   // kind [1:0]
   output logic        rsp_tlast
);

   logic [COUNT_W-1:0]           count_ff, count_in;
   result_type [RESULTS_MAX-1:0] entry_ff, entry_in;
   logic                         pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign can_load   = (count_ff == '0) ||
                       ((count_ff == COUNT_W'(1)) && rsp_tready);

   always_comb begin
      count_in = count_ff;
      entry_in = entry_ff;
      if (load) begin
         count_in = bundle.count;
         entry_in = bundle.entry;
      end else if (pop) begin
         // advance the queue by one word
         count_in = count_ff - COUNT_W'(1);
         for (int i = 0; i < RESULTS_MAX - 1; i++) begin
            entry_in[i] = entry_ff[i+1];
         end
         entry_in[RESULTS_MAX-1] = entry_ff[RESULTS_MAX-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      entry_ff <= entry_in;
   end

   assign rsp_tdata = {4'd0, entry_ff[0].status, entry_ff[0].byte_index,
                       entry_ff[0].data_byte};
   assign rsp_tuser = entry_ff[0].kind;
   assign rsp_tlast = entry_ff[0].last;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> can_load)
      else $error("result stage loaded while words still pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(RESULTS_MAX))
      else $error("result count out of range");

   a_shift_order: assert property (@(posedge clock) disable iff (reset)
      (pop && !load && count_ff > COUNT_W'(1)) |=> entry_ff[0] == $past(entry_ff[1]))
      else $error("result words out of order");

   a_last_on_command: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser == KIND_COMMAND)
      else $error("last flag on a non-command word");

endmodule

// ===== design/register_query_frame_link.sv =====
`timescale 1ns / 1ps

// Query link master. A start word (tuser 0) sends a four-word command: header,
// prefix, register id and the inverted 8-bit sum of those three, tlast on the
// fourth, and opens a reply frame. Reply bytes (tuser 1) are echoed with their
// index and checked for length, error pair and checksum; ticks (tuser 2) run the
// timeout. A frame status word ends every frame that is closed by the partner's
// reply or the timeout. All decisions for an item are made in the cycle it is
// accepted; its result words then leave one per cycle while rsp_tready is high,
// from a four-entry output stage, and the next item is taken only once the stage
// is empty or its last word is leaving. Configuration writes are taken in any cycle.
module register_query_frame_link import rqfl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // register_id [7:0], rx_byte [15:8]
   input  logic [1:0]  req_tuser,   // mode [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // data_byte [7:0], byte_index [16:8], status [19:17]
   output logic [1:0]  rsp_tuser,   // kind [1:0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [7:0]  header_ff, prefix_ff, err1_ff, err2_ff;
   logic [8:0]  init_len_ff, max_len_ff;
   logic [15:0] timeout_ff;

   logic        waiting_ff, waiting_in;
   logic [8:0]  count_ff, count_in;
   logic [8:0]  exp_len_ff, exp_len_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  first_ff, first_in;
   logic [15:0] ticks_ff, ticks_in;

   logic        accept, can_load;
   bundle_type  bundle;
   logic [7:0]  reg_id, rx_byte;
   logic [8:0]  next_count, len_new;
   logic [7:0]  want_sum;

   function automatic result_type make_result(kind_type k, logic [7:0] d,
                                              logic [8:0] idx, status_type st,
                                              logic l);
      result_type r;
      r.kind       = k;
      r.data_byte  = d;
      r.byte_index = idx;
      r.status     = st;
      r.last       = l;
      return r;
   endfunction

   assign reg_id     = req_tdata[7:0];
   assign rx_byte    = req_tdata[15:8];
   assign req_tready = can_load;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff   <= HEADER_RESET;
         prefix_ff   <= PREFIX_RESET;
         err1_ff     <= ERR1_RESET;
         err2_ff     <= ERR2_RESET;
         init_len_ff <= INIT_LEN_RESET;
         max_len_ff  <= MAX_LEN_RESET;
         timeout_ff  <= TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_HEADER:   header_ff   <= csr_data[7:0];
            REG_PREFIX:   prefix_ff   <= csr_data[7:0];
            REG_ERR1:     err1_ff     <= csr_data[7:0];
            REG_ERR2:     err2_ff     <= csr_data[7:0];
            REG_INIT_LEN: init_len_ff <= csr_data[8:0];
            REG_MAX_LEN:  max_len_ff  <= csr_data[8:0];
            REG_TIMEOUT:  timeout_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      waiting_in   = waiting_ff;
      count_in     = count_ff;
      exp_len_in   = exp_len_ff;
      sum_in       = sum_ff;
      first_in     = first_ff;
      ticks_in     = ticks_ff;
      bundle.count = '0;
      bundle.entry = '0;
      next_count   = count_ff + 9'd1;
      len_new      = {1'b0, rx_byte} + 9'd2;
      want_sum     = (next_count == 9'd1) ? 8'd0 : ~sum_ff;

      unique case (mode_type'(req_tuser))
         MODE_START: begin
            bundle.count    = COUNT_W'(4);
            bundle.entry[0] = make_result(KIND_COMMAND, header_ff, 9'd0, STATUS_OK, 1'b0);
            bundle.entry[1] = make_result(KIND_COMMAND, prefix_ff, 9'd1, STATUS_OK, 1'b0);
            bundle.entry[2] = make_result(KIND_COMMAND, reg_id, 9'd2, STATUS_OK, 1'b0);
            bundle.entry[3] = make_result(KIND_COMMAND, ~(header_ff + prefix_ff + reg_id),
                                          9'd3, STATUS_OK, 1'b1);
            waiting_in = 1'b1;
            count_in   = '0;
            exp_len_in = init_len_ff;
            sum_in     = '0;
            first_in   = '0;
            ticks_in   = '0;
         end
         MODE_BYTE: begin
            if (waiting_ff) begin
               if (count_ff >= max_len_ff) begin
                  // buffer full: drop the byte, close with bad length
                  bundle.count    = COUNT_W'(1);
                  bundle.entry[0] = make_result(KIND_STATUS, 8'd0, 9'd0,
                                                STATUS_BAD_LENGTH, 1'b0);
                  waiting_in      = 1'b0;
               end else begin
                  bundle.count    = COUNT_W'(1);
                  bundle.entry[0] = make_result(KIND_ECHO, rx_byte, count_ff,
                                                STATUS_OK, 1'b0);
                  bundle.entry[1] = make_result(KIND_STATUS, 8'd0, 9'd0, STATUS_OK, 1'b0);
                  if (count_ff == 9'd0) begin
                     first_in = rx_byte;
                  end
                  count_in = next_count;
                  if (next_count == 9'(LENGTH_INDEX + 1)) begin
                     exp_len_in = len_new;
                  end
                  priority if ((next_count == 9'(LENGTH_INDEX + 1)) &&
                               (len_new > max_len_ff)) begin
                     bundle.count           = COUNT_W'(2);
                     bundle.entry[1].status = STATUS_BAD_LENGTH;
                     waiting_in             = 1'b0;
                  end else if ((next_count == 9'd2) && (first_ff == err1_ff) &&
                               (rx_byte == err2_ff)) begin
                     bundle.count           = COUNT_W'(2);
                     bundle.entry[1].status = STATUS_ERROR_REPLY;
                     waiting_in             = 1'b0;
                  end else if (next_count >= exp_len_in) begin
                     bundle.count           = COUNT_W'(2);
                     bundle.entry[1].status = (want_sum == rx_byte) ? STATUS_OK
                                                                    : STATUS_CHECKSUM;
                     waiting_in             = 1'b0;
                  end else begin
                     sum_in = sum_ff + rx_byte;
                  end
               end
            end
         end
         MODE_TICK: begin
            if (waiting_ff) begin
               // saturate the tick count
               ticks_in = (ticks_ff != 16'hFFFF) ? ticks_ff + 16'd1 : ticks_ff;
               if (ticks_in >= timeout_ff) begin
                  bundle.count    = COUNT_W'(1);
                  bundle.entry[0] = make_result(KIND_STATUS, 8'd0, 9'd0,
                                                (count_ff == 9'd0) ? STATUS_TIMEOUT_EMPTY
                                                                   : STATUS_TIMEOUT_PART,
                                                1'b0);
                  waiting_in      = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff <= 1'b0;
         count_ff   <= '0;
         exp_len_ff <= '0;
         sum_ff     <= '0;
         first_ff   <= '0;
         ticks_ff   <= '0;
      end else if (accept) begin
         waiting_ff <= waiting_in;
         count_ff   <= count_in;
         exp_len_ff <= exp_len_in;
         sum_ff     <= sum_in;
         first_ff   <= first_in;
         ticks_ff   <= ticks_in;
      end
   end

   rqfl_result_stage u_result_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (accept && (bundle.count != '0)),
      .bundle     (bundle),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (accept && !waiting_ff && req_tuser != MODE_START) |=> !rsp_tvalid)
      else $error("result produced for an item while no frame is open");

   a_start_opens: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == MODE_START) |=> waiting_ff && count_ff == 9'd0)
      else $error("start did not open a fresh frame");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (accept && waiting_ff && req_tuser == MODE_BYTE && count_ff >= max_len_ff)
      |=> $stable(count_ff) && !waiting_ff)
      else $error("byte taken into a full buffer");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import rqfl_pkg::*;

   // Mode code that the block has no meaning for
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS  = 100;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 4000;

   class frame_scoreboard;
      result_type expected_words[$];
      int errors;

      logic [7:0]  header, prefix, err_first, err_second;
      logic [8:0]  init_len, max_len;
      logic [15:0] timeout;

      bit          frame_open;
      logic [8:0]  rx_count, frame_len;
      logic [7:0]  rx_sum, rx_first;
      logic [15:0] tick_count;

      function new();
         errors     = 0;
         header     = HEADER_RESET;
         prefix     = PREFIX_RESET;
         err_first  = ERR1_RESET;
         err_second = ERR2_RESET;
         init_len   = INIT_LEN_RESET;
         max_len    = MAX_LEN_RESET;
         timeout    = TIMEOUT_RESET;
         frame_open = 1'b0;
         rx_count   = '0;
         frame_len  = '0;
         rx_sum     = '0;
         rx_first   = '0;
         tick_count = '0;
      endfunction

      function void set_reg(reg_index_type idx, logic [15:0] value);
         case (idx)
            REG_HEADER:   header     = value[7:0];
            REG_PREFIX:   prefix     = value[7:0];
            REG_ERR1:     err_first  = value[7:0];
            REG_ERR2:     err_second = value[7:0];
            REG_INIT_LEN: init_len   = value[8:0];
            REG_MAX_LEN:  max_len    = value[8:0];
            REG_TIMEOUT:  timeout    = value[15:0];
            default: ;
         endcase
      endfunction

      function void push_word(kind_type kind, logic [7:0] data, logic [8:0] index,
                              status_type status, logic last);
         result_type word;
         word.kind       = kind;
         word.data_byte  = data;
         word.byte_index = index;
         word.status     = status;
         word.last       = last;
         expected_words.insert(expected_words.size(), word);
      endfunction

      function void close_frame(status_type status);
         push_word(KIND_STATUS, 8'd0, 9'd0, status, 1'b0);
         frame_open = 1'b0;
      endfunction

      function void predict_item(logic [1:0] mode, logic [7:0] id, logic [7:0] rx);
         logic [7:0] check_byte;
         logic [7:0] want;
         if (mode == MODE_START) begin
            check_byte = ~(header + prefix + id);
            push_word(KIND_COMMAND, header, 9'd0, STATUS_OK, 1'b0);
            push_word(KIND_COMMAND, prefix, 9'd1, STATUS_OK, 1'b0);
            push_word(KIND_COMMAND, id, 9'd2, STATUS_OK, 1'b0);
            push_word(KIND_COMMAND, check_byte, 9'd3, STATUS_OK, 1'b1);
            frame_open = 1'b1;
            rx_count   = '0;
            frame_len  = init_len;
            rx_sum     = '0;
            rx_first   = '0;
            tick_count = '0;
         end else if (mode == MODE_BYTE) begin
            if (!frame_open) return;
            // buffer already full: no echo
            if (rx_count >= max_len) begin
               close_frame(STATUS_BAD_LENGTH);
               return;
            end
            push_word(KIND_ECHO, rx, rx_count, STATUS_OK, 1'b0);
            if (rx_count == 9'd0) rx_first = rx;
            rx_count = rx_count + 9'd1;
            if (rx_count == LENGTH_INDEX + 1) begin
               frame_len = {1'b0, rx} + 9'd2;
               if (frame_len > max_len) begin
                  close_frame(STATUS_BAD_LENGTH);
                  return;
               end
            end
            if (rx_count == 9'd2 && rx_first == err_first && rx == err_second) begin
               close_frame(STATUS_ERROR_REPLY);
               return;
            end
            if (rx_count >= frame_len) begin
               want = (rx_count == 9'd1) ? 8'd0 : ~rx_sum;
               close_frame((want == rx) ? STATUS_OK : STATUS_CHECKSUM);
               return;
            end
            rx_sum = rx_sum + rx;
         end else if (mode == MODE_TICK) begin
            if (!frame_open) return;
            if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
            if (tick_count >= timeout)
               close_frame((rx_count == 9'd0) ? STATUS_TIMEOUT_EMPTY : STATUS_TIMEOUT_PART);
         end
      endfunction

      function void check_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_word(result_type got);
         result_type want;
         if (expected_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual kind %0d data %0h index %0d status %0d last %0b",
                     $time, got.kind, got.data_byte, got.byte_index, got.status, got.last);
            return;
         end
         want = expected_words.pop_front();
         check_field("kind", want.kind, got.kind);
         check_field("data_byte", want.data_byte, got.data_byte);
         check_field("byte_index", want.byte_index, got.byte_index);
         check_field("status", want.status, got.status);
         check_field("last", want.last, got.last);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   frame_scoreboard sb = new();
   int send_idle_pct = 0;
   int stall_pct = 0;
   int sent_items = 0;
   int random_base = 0;

   register_query_frame_link u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : result_monitor
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind       = kind_type'(rsp_tuser);
         got.data_byte  = rsp_tdata[7:0];
         got.byte_index = rsp_tdata[16:8];
         got.status     = status_type'(rsp_tdata[19:17]);
         got.last       = rsp_tlast;
         sb.check_word(got);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(255));
   endfunction

   task automatic send_item(input logic [1:0] mode, input logic [7:0] id,
                            input logic [7:0] rx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {rx, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.predict_item(mode, id, rx);
      sent_items++;
   endtask

   task automatic send_start();
      send_item(MODE_START, any_byte(), any_byte());
   endtask

   task automatic send_tick();
      send_item(MODE_TICK, any_byte(), any_byte());
   endtask

   task automatic send_byte(input logic [7:0] rx);
      send_item(MODE_BYTE, any_byte(), rx);
   endtask

   // Hold off the sender until every predicted word has come out
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] header, input logic [7:0] prefix,
                            input logic [7:0] err_first, input logic [7:0] err_second,
                            input logic [8:0] init_len, input logic [8:0] max_len,
                            input logic [15:0] timeout);
      drain();
      write_reg(REG_HEADER, {8'd0, header});
      write_reg(REG_PREFIX, {8'd0, prefix});
      write_reg(REG_ERR1, {8'd0, err_first});
      write_reg(REG_ERR2, {8'd0, err_second});
      write_reg(REG_INIT_LEN, {7'd0, init_len});
      write_reg(REG_MAX_LEN, {7'd0, max_len});
      write_reg(REG_TIMEOUT, timeout);
   endtask

   // Reply frame with the given length byte; the last byte carries the
   // inverted sum unless corrupted, truncation drops the tail, and the
   // partner stops once the frame is closed
   task automatic send_reply(input int unsigned len_byte, input bit corrupt,
                             input bit truncate, input int unsigned tick_pct);
      logic [7:0] frame[$];
      logic [7:0] total;
      int unsigned n;
      int unsigned keep;
      n = (len_byte < 2) ? 3 : len_byte + 2;
      for (int unsigned i = 0; i < n; i++) frame.insert(frame.size(), any_byte());
      frame[2] = 8'(len_byte);
      if (n == 3) begin
         // the length byte is also the last: fix the sum through byte one
         frame[1] = ~frame[2] - frame[0];
         if (corrupt) frame[1] = frame[1] ^ 8'($urandom_range(1, 255));
      end else begin
         total = 8'd0;
         for (int unsigned i = 0; i < n - 1; i++) total = total + frame[i];
         frame[n-1] = ~total;
         if (corrupt) frame[n-1] = frame[n-1] ^ 8'($urandom_range(1, 255));
      end
      keep = truncate ? $urandom_range(0, n - 1) : n;
      for (int unsigned i = 0; i < keep; i++) begin
         if (!sb.frame_open) break;
         if ($urandom_range(99) < tick_pct) send_tick();
         send_byte(frame[i]);
      end
   endtask

   task automatic run_transaction();
      int r;
      int unsigned len_byte;
      int unsigned ticks;
      r = $urandom_range(99);
      len_byte = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      ticks = (sb.timeout < 40) ? sb.timeout : 40;
      if (r < 88) send_start();
      if (r < 55) begin
         send_reply(len_byte, 1'b0, 1'b0, 10);
      end else if (r < 65) begin
         send_reply(len_byte, 1'b1, 1'b0, 10);
      end else if (r < 75) begin
         send_reply(len_byte, 1'b0, 1'b1, 0);
         repeat (ticks) send_tick();
      end else if (r < 82) begin
         send_byte(sb.err_first);
         send_byte(sb.err_second);
         repeat ($urandom_range(0, 2)) send_byte(any_byte());
      end else if (r < 88) begin
         // length byte above the maximum wherever the buffer leaves room for one
         send_reply((sb.max_len < 9'd257) ? $urandom_range(sb.max_len - 9'd1, 255)
                                          : $urandom_range(0, 12),
                    1'($urandom_range(1)), 1'b0, 0);
      end else if (r < 95) begin
         repeat ($urandom_range(1, 6)) send_item(2'($urandom_range(3)), any_byte(), any_byte());
      end else begin
         drain();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(8'hFF, 8'hFF, 8'hE1, 8'h1E, 9'd3, 9'd257, 16'd3);
      // header and prefix wrap the command sum
      send_item(MODE_START, 8'hFF, any_byte());
      send_reply(1, 1'b0, 1'b0, 0);
      // nothing open: ignore ticks, bytes and the unused mode
      send_tick();
      send_byte(any_byte());
      send_item(MODE_UNUSED, any_byte(), any_byte());
      // no reply at all
      send_item(MODE_START, 8'h00, any_byte());
      repeat (3) send_tick();
      // restart drops the open frame, then the partner answers with its error pair
      send_start();
      send_byte(any_byte());
      send_start();
      send_byte(8'hE1);
      send_byte(8'h1E);
      // reply cut short by the timeout
      send_start();
      send_byte(any_byte());
      send_byte(any_byte());
      repeat (3) send_tick();
      // length of zero ends the frame on the length byte
      send_start();
      send_reply(0, 1'b0, 1'b0, 0);
      send_start();
      send_reply(2, 1'b1, 1'b0, 0);
      // length over the maximum
      configure(8'h00, 8'h00, 8'h00, 8'h00, 9'd257, 9'd3, 16'hFFFF);
      send_start();
      send_reply(5, 1'b0, 1'b0, 0);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               configure(any_byte(), any_byte(), any_byte(), any_byte(), 9'd3, 9'd257,
                         16'hFFFF);
               send_idle_pct = 0;
               stall_pct = 0;
               // long frame under the widest buffer
               send_start();
               send_reply(40, 1'b0, 1'b0, 0);
            end
            1: begin
               configure(any_byte(), any_byte(), any_byte(), any_byte(),
                         9'($urandom_range(3, 257)), 9'($urandom_range(3, 40)),
                         16'($urandom_range(1, 30)));
               send_idle_pct = 65;
               stall_pct = 0;
            end
            2: begin
               configure(8'h00, 8'hFF, 8'hFF, 8'hFF, 9'd257, 9'd3, 16'd1);
               send_idle_pct = 0;
               stall_pct = 65;
            end
            default: begin
               configure(any_byte(), any_byte(), any_byte(), any_byte(),
                         9'($urandom_range(3, 257)), 9'($urandom_range(3, 257)),
                         $urandom_range(1) ? 16'($urandom_range(1, 40))
                                           : 16'($urandom_range(41, 65535)));
               send_idle_pct = 11;
               stall_pct = 11;
            end
         endcase
         random_base = sent_items;
         while (sent_items < random_base + RANDOM_ITEMS / 4) run_transaction();
      end

      drain();
      if (sb.errors == 0 && sb.expected_words.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== register_query_frame_link.f =====
design/rqfl_pkg.sv
design/rqfl_result_stage.sv
design/register_query_frame_link.sv
tb/tb.sv
